>>> design/llsc_pkg.sv
`default_nettype none

package llsc_pkg;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned TID_W  = 4;
	localparam int unsigned ADDR_W = 12;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned KIND_W = 3;

	localparam int unsigned THREAD_COUNT_DEF = 16;
	localparam int unsigned MEMORY_WORDS_DEF = 4096;

	typedef enum logic [MODE_W-1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_LINK  = 2'd2,
		MODE_COND  = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ  = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_LINK  = 3'd2,
		KIND_ACK   = 3'd3,
		KIND_NACK  = 3'd4
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming request
		logic access;    // memory access and link update
		logic load_out;  // load the output register
	} cmd_t;

endpackage

`default_nettype wire

>>> design/llsc_ram.sv
`default_nettype none

module llsc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/llsc_ctrl.sv
`default_nettype none

module llsc_ctrl (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  wire logic   out_stall,
	output llsc_pkg::cmd_t cmd
);

	import llsc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_ACCESS = 3'b010,
		S_RESULT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.access   = (state_q == S_ACCESS);
		cmd.load_out = (state_q == S_RESULT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_ACCESS;
				end
			end
			S_ACCESS: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// every access follows an accepted request
	a_access_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.access |-> $past(in_valid && !in_stall))
		else $error("access without accepted request");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// no new request is taken between capture and result load
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> in_stall ##1 in_stall)
		else $error("request accepted while one is in flight");
`endif

endmodule

`default_nettype wire

>>> design/llsc_datapath.sv
`default_nettype none

module llsc_datapath #(
	parameter int unsigned THREAD_COUNT = llsc_pkg::THREAD_COUNT_DEF,
	parameter int unsigned MEMORY_WORDS = llsc_pkg::MEMORY_WORDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire llsc_pkg::cmd_t              cmd,
	input  wire logic [llsc_pkg::MODE_W-1:0] mode,
	input  wire logic [llsc_pkg::TID_W-1:0]  thread_id,
	input  wire logic [llsc_pkg::ADDR_W-1:0] word_address,
	input  wire logic [llsc_pkg::DATA_W-1:0] write_data,
	output logic      [llsc_pkg::DATA_W-1:0] result_data,
	output logic      [llsc_pkg::KIND_W-1:0] reply_kind
);

	import llsc_pkg::*;

	localparam int unsigned AW       = $clog2(MEMORY_WORDS);
	localparam int unsigned THREAD_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	// addresses below 4096 never wrap when the memory is at least that deep
	localparam int unsigned WRAP_M   = (MEMORY_WORDS < 4096) ? MEMORY_WORDS : 4096;
	localparam int unsigned WRAP_W   = $clog2(WRAP_M);
	// shift of address width plus divisor width makes the reciprocal exact
	localparam int unsigned SHIFT    = ADDR_W + WRAP_W;
	localparam int unsigned RECIP    = ((32'd1 << SHIFT) + WRAP_M - 1) / WRAP_M;
	localparam int unsigned RECIP_W  = ADDR_W + 2;
	localparam int unsigned PROD_W   = ADDR_W + RECIP_W;

	mode_t               mode_q;
	logic [TID_W-1:0]    tid_q;
	logic                tid_ok_q;
	logic [AW-1:0]       addr_q;
	logic [DATA_W-1:0]   data_q;
	logic                sc_ok_q;
	logic [DATA_W-1:0]   result_data_q;
	kind_t               reply_kind_q;

	logic [THREAD_COUNT-1:0] link_valid_q;
	logic [AW-1:0]           link_addr_q [THREAD_COUNT];

	logic [PROD_W-1:0]       prod;
	logic [ADDR_W-1:0]       quot;
	logic [ADDR_W-1:0]       rem;
	logic [THREAD_W-1:0]     tid_idx;
	logic                    sc_ok;
	logic [THREAD_COUNT-1:0] addr_hit;
	logic [THREAD_COUNT-1:0] own;
	logic [THREAD_COUNT-1:0] other_hits;
	logic                    ram_we;
	logic                    ram_re;
	logic [DATA_W-1:0]       ram_rdata;

	// address wrap: quotient by reciprocal multiplication, then one subtract
	assign prod = PROD_W'(word_address) * PROD_W'(RECIP);
	assign quot = ADDR_W'(prod >> SHIFT);
	assign rem  = word_address - ADDR_W'(quot * WRAP_M);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(mode);
			tid_q    <= thread_id;
			tid_ok_q <= (32'(thread_id) < 32'(THREAD_COUNT));
			addr_q   <= AW'(rem);
			data_q   <= write_data;
		end
	end

	assign tid_idx = THREAD_W'(tid_q);

	always_comb begin
		for (int i = 0; i < THREAD_COUNT; i++) begin
			addr_hit[i] = link_valid_q[i] && (link_addr_q[i] == addr_q);
			own[i]      = (THREAD_W'(i) == tid_idx);
		end
	end

	assign other_hits = addr_hit & ~own;
	assign sc_ok      = tid_ok_q && |(addr_hit & own);

	assign ram_we = cmd.access && ((mode_q == MODE_WRITE) || ((mode_q == MODE_COND) && sc_ok));
	assign ram_re = cmd.access && ((mode_q == MODE_READ) || (mode_q == MODE_LINK));

	llsc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEMORY_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (addr_q),
		.wdata (data_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_valid_q <= '0;
		end else if (cmd.access) begin
			if (mode_q == MODE_LINK && tid_ok_q) begin
				link_valid_q[tid_idx] <= 1'b1;
			end else if (mode_q == MODE_COND && sc_ok) begin
				link_valid_q <= link_valid_q & ~other_hits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access && mode_q == MODE_LINK && tid_ok_q) begin
			link_addr_q[tid_idx] <= addr_q;
		end
		if (cmd.access) begin
			sc_ok_q <= sc_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (mode_q)
				MODE_READ: begin
					result_data_q <= ram_rdata;
					reply_kind_q  <= KIND_READ;
				end
				MODE_WRITE: begin
					result_data_q <= data_q;
					reply_kind_q  <= KIND_WRITE;
				end
				MODE_LINK: begin
					result_data_q <= ram_rdata;
					reply_kind_q  <= KIND_LINK;
				end
				MODE_COND: begin
					result_data_q <= DATA_W'(sc_ok_q);
					reply_kind_q  <= sc_ok_q ? KIND_ACK : KIND_NACK;
				end
				default: begin
					result_data_q <= '0;
					reply_kind_q  <= KIND_NACK;
				end
			endcase
		end
	end

	assign result_data = result_data_q;
	assign reply_kind  = reply_kind_q;

`ifndef ASSERT_OFF
	// successful conditional store leaves no rival link on the address
	a_rivals_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.access && mode_q == MODE_COND && sc_ok |=> other_hits == '0)
		else $error("rival link survived successful store-conditional");

	// requester keeps its link after success
	a_own_link_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.access && mode_q == MODE_COND && sc_ok |=> link_valid_q[tid_idx])
		else $error("requester link lost on store-conditional");

	// a plain write never touches the link monitor
	a_write_keeps_links: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.access && mode_q == MODE_WRITE |=> $stable(link_valid_q))
		else $error("plain write changed a link");
`endif

endmodule

`default_nettype wire

>>> design/load_linked_store_conditional_memory.sv
// Word memory with a per-thread reservation monitor. A request carries a mode (read, write,
// load-linked, store-conditional), a thread id, a word address and a data word, and gives
// exactly one reply. Addresses wrap modulo MEMORY_WORDS. Each request passes through three steps:
// capture, one access of the single-port memory, and the load of the output register; the
// read of that memory is registered. A reply waiting in the output register
// does not hold off the next request, which is taken while the reply is stalled. Memory
// words hold no reset value: read a word only after writing it.
`default_nettype none

module load_linked_store_conditional_memory #(
	parameter int unsigned THREAD_COUNT = llsc_pkg::THREAD_COUNT_DEF,
	parameter int unsigned MEMORY_WORDS = llsc_pkg::MEMORY_WORDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [llsc_pkg::MODE_W-1:0] mode,
	input  wire logic [llsc_pkg::TID_W-1:0]  thread_id,
	input  wire logic [llsc_pkg::ADDR_W-1:0] word_address,
	input  wire logic [llsc_pkg::DATA_W-1:0] write_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [llsc_pkg::DATA_W-1:0] result_data,
	output logic      [llsc_pkg::KIND_W-1:0] reply_kind
);

	import llsc_pkg::*;

	cmd_t cmd;

	llsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	llsc_datapath #(
		.THREAD_COUNT (THREAD_COUNT),
		.MEMORY_WORDS (MEMORY_WORDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.thread_id    (thread_id),
		.word_address (word_address),
		.write_data   (write_data),
		.result_data  (result_data),
		.reply_kind   (reply_kind)
	);

endmodule

`default_nettype wire

>>> bench/load_linked_store_conditional_memory_tb.sv
`timescale 1ns / 100ps

module load_linked_store_conditional_memory_tb;
	import llsc_pkg::*;

	localparam int unsigned THREADS = THREAD_COUNT_DEF;
	localparam int unsigned WORDS   = MEMORY_WORDS_DEF;
	localparam int unsigned PHASE_ITEMS = 610;

	typedef struct {
		logic [DATA_W-1:0] data;
		kind_t             kind;
	} reply_t;

	typedef struct {
		mode_t             m;
		logic [TID_W-1:0]  tid;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		bit                typed;
		logic [DATA_W-1:0] want_data;
		kind_t             want_kind;
	} request_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [MODE_W-1:0]   mode;
	logic [TID_W-1:0]    thread_id;
	logic [ADDR_W-1:0]   word_address;
	logic [DATA_W-1:0]   write_data;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DATA_W-1:0]   result_data;
	logic [KIND_W-1:0]   reply_kind;

	// shadow of the block: links and memory words
	bit                  link_held [THREADS];
	logic [ADDR_W-1:0]   link_addr [THREADS];
	logic [DATA_W-1:0]   word_model [WORDS];
	bit                  word_written [WORDS];
	logic [ADDR_W-1:0]   written_addrs [$];

	reply_t              pending_replies [$];
	int unsigned         mismatch_count = 0;
	int unsigned         send_idle_pct = 7;
	int unsigned         recv_idle_pct = 49;

	// typed results only where they are obvious; the rest come from the shadow
	request_row_t directed_rows [21] = '{
		'{MODE_COND,  4'd0,  12'd0,    32'hDEADBEEF, 1'b1, 32'd0,        KIND_NACK},
		'{MODE_WRITE, 4'd0,  12'd0,    32'h00000000, 1'b1, 32'h00000000, KIND_WRITE},
		'{MODE_WRITE, 4'd15, 12'd4095, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, KIND_WRITE},
		'{MODE_READ,  4'd0,  12'd0,    32'h00000000, 1'b1, 32'h00000000, KIND_READ},
		'{MODE_READ,  4'd15, 12'd4095, 32'h00000000, 1'b1, 32'hFFFFFFFF, KIND_READ},
		'{MODE_LINK,  4'd0,  12'd0,    32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_LINK,  4'd1,  12'd0,    32'hFFFFFFFF, 1'b0, 32'd0,        KIND_READ},
		'{MODE_LINK,  4'd15, 12'd4095, 32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_WRITE, 4'd2,  12'd0,    32'h12345678, 1'b1, 32'h12345678, KIND_WRITE},
		'{MODE_COND,  4'd1,  12'd0,    32'hA5A5A5A5, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd0,  12'd0,    32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd1,  12'd0,    32'h5A5A5A5A, 1'b0, 32'd0,        KIND_READ},
		'{MODE_READ,  4'd3,  12'd0,    32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd15, 12'd4094, 32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd15, 12'd4095, 32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_LINK,  4'd7,  12'd4095, 32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_LINK,  4'd7,  12'd0,    32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd7,  12'd4095, 32'hFFFFFFFF, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd7,  12'd0,    32'hFFFFFFFF, 1'b0, 32'd0,        KIND_READ},
		'{MODE_COND,  4'd5,  12'd4095, 32'h00000000, 1'b0, 32'd0,        KIND_READ},
		'{MODE_READ,  4'd8,  12'd4095, 32'h00000000, 1'b0, 32'd0,        KIND_READ}
	};

	load_linked_store_conditional_memory uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.thread_id    (thread_id),
		.word_address (word_address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_data  (result_data),
		.reply_kind   (reply_kind)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void predict_reply(input mode_t m, input logic [TID_W-1:0] t,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d, output reply_t r);
		int i;
		r.data = '0;
		r.kind = KIND_READ;
		case (m)
			MODE_READ: begin
				r.data = word_model[a];
				r.kind = KIND_READ;
			end
			MODE_WRITE: begin
				word_model[a] = d;
				if (!word_written[a])
					written_addrs.push_back(a);
				word_written[a] = 1'b1;
				r.data = d;
				r.kind = KIND_WRITE;
			end
			MODE_LINK: begin
				link_held[t] = 1'b1;
				link_addr[t] = a;
				r.data = word_model[a];
				r.kind = KIND_LINK;
			end
			default: begin
				if (link_held[t] && link_addr[t] == a) begin
					word_model[a] = d;
					// the winner keeps its own link; rivals on this word lose theirs
					for (i = 0; i < THREADS; i++)
						if (i != t && link_held[i] && link_addr[i] == a)
							link_held[i] = 1'b0;
					r.data = 32'd1;
					r.kind = KIND_ACK;
				end else begin
					r.data = 32'd0;
					r.kind = KIND_NACK;
				end
			end
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_written_addr();
		if (written_addrs.size() == 0)
			return ADDR_W'($urandom_range(WORDS - 1));
		return written_addrs[$urandom_range(written_addrs.size() - 1)];
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input mode_t m, input logic [TID_W-1:0] t,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
			input bit typed, input logic [DATA_W-1:0] want_data, input kind_t want_kind);
		reply_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		thread_id    <= t;
		word_address <= a;
		write_data   <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_reply(m, t, a, d, r);
		if (typed) begin
			r.data = want_data;
			r.kind = want_kind;
		end
		pending_replies.push_back(r);
		@(negedge clk);
	endtask

	// any mode; reads and load-linked only touch words already written
	task automatic send_random(input logic [ADDR_W-1:0] hint);
		mode_t             m;
		logic [TID_W-1:0]  t;
		logic [ADDR_W-1:0] a;
		m = mode_t'($urandom_range(3));
		t = TID_W'($urandom_range(THREADS - 1));
		case ($urandom_range(3))
			0, 1: a = hint;
			2: a = pick_written_addr();
			default: a = ADDR_W'($urandom_range(WORDS - 1));
		endcase
		if (m == MODE_COND && link_held[t] && $urandom_range(1))
			a = link_addr[t];
		if (!word_written[a] && (m == MODE_READ || m == MODE_LINK))
			m = MODE_WRITE;
		send_request(m, t, a, $urandom, 1'b0, '0, KIND_READ);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned       sent;
		logic [TID_W-1:0]  t;
		logic [ADDR_W-1:0] a;
		int unsigned       gap;
		sent = 0;
		while (sent < count) begin
			if (written_addrs.size() == 0 || $urandom_range(99) < 25) begin
				send_random(pick_written_addr());
				sent++;
			end else begin
				// link, up to three random requests, then the conditional store
				t = TID_W'($urandom_range(THREADS - 1));
				a = pick_written_addr();
				send_request(MODE_LINK, t, a, $urandom, 1'b0, '0, KIND_READ);
				gap = $urandom_range(3);
				repeat (gap)
					send_random(a);
				if ($urandom_range(9) < 8)
					send_request(MODE_COND, t, a, $urandom, 1'b0, '0, KIND_READ);
				else
					send_request(MODE_COND, t, pick_written_addr(), $urandom, 1'b0, '0,
						KIND_READ);
				sent += gap + 2;
			end
		end
	endtask

	always @(negedge clk)
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with no request outstanding: data %h kind %0d",
					$time, result_data, reply_kind);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (result_data !== want.data) begin
					$display("%0t: result_data expected %h actual %h",
						$time, want.data, result_data);
					mismatch_count++;
				end
				if (reply_kind !== want.kind) begin
					$display("%0t: reply_kind expected %0d actual %0d",
						$time, want.kind, reply_kind);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_READ;
		thread_id    = '0;
		word_address = '0;
		write_data   = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].m, directed_rows[i].tid, directed_rows[i].addr,
				directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want_data,
				directed_rows[i].want_kind);

		run_random(PHASE_ITEMS);
		send_idle_pct = 49;
		recv_idle_pct = 7;
		run_random(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);
		in_valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
